// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the stack RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// Types and constants for the minimum-tracking stack.
// Used by mts_stack_mem and min_tracking_stack; depends on nothing.
`timescale 1ns / 1ps

package mts_pkg;

    // Stored stack word: wide enough for 2*value - minimum
    typedef logic signed [33:0] t_word;

    typedef struct packed {
        logic        [1:0]  op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic        [1:0]  status;
    } t_out_item;

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    localparam logic signed [31:0] INT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NO_VALUE = -32'sd1;

endpackage

// ===== rtl/core/min_tracking_stack.sv =====
// Stack of signed 32-bit values that reports its minimum with every item, keeping
// no second stack: a push below the minimum stores 2*value-minimum instead, and a
// pop of such a word restores the earlier minimum. Each input item gives one result
// item with the popped value, the top, the minimum, the empty flag and a status.
// Push, query and refused items go straight to the result register; a pop of
// an entry waits in S_LOAD for the new top from the memory's registered read port.
// The top word is held in a register, so no clearing pass is needed after reset.
// Depends on mts_pkg, mts_stack_mem and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_tracking_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mts_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mts_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic signed [31:0]  r_min, n_min;
    mts_pkg::t_word      r_top_word, n_top_word;
    logic signed [31:0]  r_pop_val;
    logic                r_out_valid;
    mts_pkg::t_out_item  r_out;

    logic                in_acc;
    logic                out_free;
    logic                pop_go;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_count;
    mts_pkg::t_word      rd_data;
    mts_pkg::t_word      val_word;
    mts_pkg::t_word      min_word;
    mts_pkg::t_word      enc_word;
    logic                top_enc;
    logic signed [31:0]  restored_min;
    logic signed [31:0]  popped_now;
    logic [1:0]          status;
    mts_pkg::t_out_item  imm_item;
    mts_pkg::t_out_item  load_item;

    // Decode a stored word against the minimum: encoded words stand for the minimum
    function automatic logic signed [31:0] f_decode(input mts_pkg::t_word w,
                                                    input logic signed [31:0] m);
        mts_pkg::t_word mw;
        mw = {{2{m[31]}}, m};
        return (w >= mw) ? w[31:0] : m;
    endfunction

    // Handshake: hold off while a pop waits on memory or the result slot is blocked
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Encoding arithmetic on the top word and the minimum
    assign val_word     = {{2{i_in_item.value[31]}}, i_in_item.value};
    assign min_word     = {{2{r_min[31]}}, r_min};
    assign enc_word     = (val_word <<< 1) - min_word;
    assign top_enc      = r_top_word < min_word;
    assign restored_min = 32'((min_word <<< 1) - r_top_word);
    assign popped_now   = top_enc ? r_min : r_top_word[31:0];
    assign rd_count     = r_count[AW-1:0] - AW'(2);

    // Next stack state for the accepted item
    always_comb begin
        n_count    = r_count;
        n_min      = r_min;
        n_top_word = r_top_word;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        pop_go     = 1'b0;
        status     = mts_pkg::ST_OK;
        if (in_acc) begin
            case (i_in_item.op)
                mts_pkg::OP_PUSH: begin
                    if (r_count == FULL_COUNT) begin
                        status = mts_pkg::ST_PUSH_FULL;
                    end else begin
                        if (r_count == '0) begin
                            n_min      = i_in_item.value;
                            n_top_word = val_word;
                        end else if (i_in_item.value < r_min) begin
                            n_min      = i_in_item.value;
                            n_top_word = enc_word;
                        end else begin
                            n_top_word = val_word;
                        end
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                mts_pkg::OP_POP: begin
                    if (r_count == '0) begin
                        status = mts_pkg::ST_POP_EMPTY;
                    end else begin
                        pop_go  = 1'b1;
                        n_min   = top_enc ? restored_min : r_min;
                        n_count = r_count - CW'(1);
                        rd_en   = (r_count > CW'(1));
                    end
                end
                default: begin
                    // query, and the unused code, change nothing
                end
            endcase
        end
    end

    // Result of an item that needs no memory read, built from the next state
    always_comb begin
        imm_item.popped_value = mts_pkg::NO_VALUE;
        imm_item.is_empty     = (n_count == '0);
        imm_item.top_value    = (n_count == '0) ? mts_pkg::NO_VALUE
                                                : f_decode(n_top_word, n_min);
        imm_item.min_value    = (n_count == '0) ? mts_pkg::NO_VALUE : n_min;
        imm_item.status       = status;
    end

    // Result of a pop, once the new top word is back from memory
    always_comb begin
        load_item.popped_value = r_pop_val;
        load_item.is_empty     = (r_count == '0);
        load_item.top_value    = (r_count == '0) ? mts_pkg::NO_VALUE
                                                 : f_decode(rd_data, r_min);
        load_item.min_value    = (r_count == '0) ? mts_pkg::NO_VALUE : r_min;
        load_item.status       = mts_pkg::ST_OK;
    end

    // Sequencer: a pop waits in S_LOAD for the read data
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (pop_go) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_min   <= mts_pkg::INT_MAX;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_min   <= n_min;
        end
    end

    // Top word register: load from memory after a pop that leaves entries, else take the next value
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            if (r_count != '0) begin
                r_top_word <= rd_data;
            end
        end else begin
            r_top_word <= n_top_word;
        end
        if (pop_go) begin
            r_pop_val <= popped_now;
        end
    end

    // Result register: fill on a finished item, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((in_acc && !pop_go) || (r_state == S_LOAD)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !pop_go) begin
            r_out <= imm_item;
        end else if (r_state == S_LOAD) begin
            r_out <= load_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Stack word memory; a pop reads only entries written by earlier pushes,
    // and reads and writes never fall in the same cycle
    mts_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (n_top_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_count),
        .o_rd_data (rd_data)
    );

    `ASSERT_CLK(a_count_bound, r_count <= FULL_COUNT, "entry count above stack depth")
    `ASSERT_CLK(a_load_slot_free, (r_state == S_LOAD) |-> !o_out_valid, "result slot busy")
    `ASSERT_CLK(a_pop_to_load, pop_go |=> (r_state == S_LOAD), "pop skipped the read wait")
    `ASSERT_CLK(a_load_count, (r_state == S_LOAD) |-> r_count == $past(r_count) - CW'(1), "bad count")
    `ASSERT_CLK(a_empty_min, (o_out_valid && o_out_item.is_empty) |-> (o_out_item.min_value == mts_pkg::NO_VALUE), "empty with minimum")

endmodule

// ===== rtl/core/mts_stack_mem.sv =====
// Single-port-write, single-port-read memory for the stack words.
// Read data is registered. Depends on mts_pkg.
`timescale 1ns / 1ps

module mts_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  mts_pkg::t_word    i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output mts_pkg::t_word    o_rd_data
);

    mts_pkg::t_word r_mem [DEPTH];
    mts_pkg::t_word r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== test/tb_min_tracking_stack.sv =====
// Testbench for min_tracking_stack: directed, fill-to-full, back-pressure and random
// item streams, each result checked against a predictor of the stack and its minimum.
// Depends on mts_pkg and the min_tracking_stack RTL.
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    localparam int DEPTH = 1024;
    localparam int RANDOM_ITEMS = 230;
    localparam int SEGMENT_ITEMS = 50;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PRESSURE_ITEMS = 64;
    localparam int TAIL_CYCLES = 20;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    // Spare op code, handled by the block as a query
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic signed [31:0] INT_MIN_VALUE = 32'sh8000_0000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    mts_pkg::t_in_item   i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mts_pkg::t_out_item  o_out_item;

    // Predicted stack contents, count and minimum
    mts_pkg::t_word     held_words [DEPTH];
    int                 held_count = 0;
    logic signed [31:0] held_min = mts_pkg::INT_MAX;

    mts_pkg::t_out_item due_reports [$];

    // Pacing controls shared by the tests and the two sides
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int out_hold_cycles = 0;

    logic signed [31:0] slope_value = 32'sd0;

    int fail_count = 0;
    int items_sent = 0;
    int reports_checked = 0;
    int encoded_pushes = 0;
    int refused_pushes = 0;
    int empty_pops = 0;
    int deepest = 0;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one item to the predicted stack and return the report it should give
    function automatic mts_pkg::t_out_item step_min_stack(mts_pkg::t_in_item item);
        mts_pkg::t_word     v_wide;
        mts_pkg::t_word     m_wide;
        mts_pkg::t_word     word;
        mts_pkg::t_word     restored;
        mts_pkg::t_out_item view;
        v_wide = {{2{item.value[31]}}, item.value};
        m_wide = {{2{held_min[31]}}, held_min};
        view.popped_value = mts_pkg::NO_VALUE;
        view.status = mts_pkg::ST_OK;
        case (item.op)
            mts_pkg::OP_PUSH: begin
                if (held_count >= DEPTH) begin
                    view.status = mts_pkg::ST_PUSH_FULL;
                    refused_pushes++;
                end else begin
                    if (held_count != 0 && v_wide < m_wide) begin
                        // store the encoded word and take the value as new minimum
                        held_words[held_count] = 2 * v_wide - m_wide;
                        held_min = item.value;
                        encoded_pushes++;
                    end else begin
                        held_words[held_count] = v_wide;
                        if (held_count == 0)
                            held_min = item.value;
                    end
                    held_count++;
                    if (held_count > deepest)
                        deepest = held_count;
                end
            end
            mts_pkg::OP_POP: begin
                if (held_count == 0) begin
                    view.status = mts_pkg::ST_POP_EMPTY;
                    empty_pops++;
                end else begin
                    word = held_words[held_count - 1];
                    if (word >= m_wide) begin
                        view.popped_value = word[31:0];
                    end else begin
                        // encoded word: give back the minimum and recover the earlier one
                        view.popped_value = held_min;
                        restored = 2 * m_wide - word;
                        held_min = restored[31:0];
                    end
                    held_count--;
                end
            end
            default: ;
        endcase
        if (held_count == 0) begin
            view.top_value = mts_pkg::NO_VALUE;
            view.min_value = mts_pkg::NO_VALUE;
            view.is_empty = 1'b1;
        end else begin
            word = held_words[held_count - 1];
            m_wide = {{2{held_min[31]}}, held_min};
            view.top_value = (word >= m_wide) ? word[31:0] : held_min;
            view.min_value = held_min;
            view.is_empty = 1'b0;
        end
        return view;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint seen);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
    endtask

    task automatic compare_report(input mts_pkg::t_out_item want,
                                  input mts_pkg::t_out_item seen);
        if (seen.popped_value !== want.popped_value)
            flag_mismatch("popped_value", want.popped_value, seen.popped_value);
        if (seen.top_value !== want.top_value)
            flag_mismatch("top_value", want.top_value, seen.top_value);
        if (seen.min_value !== want.min_value)
            flag_mismatch("min_value", want.min_value, seen.min_value);
        if (seen.is_empty !== want.is_empty)
            flag_mismatch("is_empty", want.is_empty, seen.is_empty);
        if (seen.status !== want.status)
            flag_mismatch("status", want.status, seen.status);
    endtask

    // Predict each accepted item, then check each accepted result against the oldest report
    always @(posedge i_clk) begin : track_and_check
        mts_pkg::t_out_item due;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                due_reports.push_back(step_min_stack(i_in_item));
            if (o_out_valid && !i_out_stall) begin
                if (due_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing due, popped %0d top %0d min %0d",
                             $time, o_out_item.popped_value, o_out_item.top_value,
                             o_out_item.min_value);
                end else begin
                    due = due_reports.pop_front();
                    compare_report(due, o_out_item);
                    reports_checked++;
                end
            end
        end
    end

    // Result side: hold the stall for a drawn number of cycles after each item,
    // or for a long stretch when a test asks for one
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold_cycles != 0) begin
                stall_left = out_hold_cycles;
                out_hold_cycles = 0;
            end else if (o_out_valid && !i_out_stall) begin
                stall_left = out_steady ? 0 : $urandom_range(0, 8);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // Offer one item after a drawn gap and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] value);
        int                gap;
        mts_pkg::t_in_item item;
        gap = in_steady ? 0 : $urandom_range(0, 8);
        item.op = op;
        item.value = value;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_in_item <= {2'($urandom_range(0, 3)), $urandom};
            repeat (gap) @(posedge i_clk);
        end
        i_in_item <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted report has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
    endtask

    // Push value: extremes, random or small values, the current minimum, or a downward walk
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return INT_MIN_VALUE;
            1: return mts_pkg::INT_MAX;
            2, 3: return $urandom;
            4, 5: return $signed($urandom_range(0, 64)) - 32;
            6: return held_min;
            default: begin
                // walk downwards so that many pushes land below the minimum
                if ($urandom_range(0, 15) == 0)
                    slope_value = $urandom;
                else
                    slope_value = slope_value - $signed($urandom_range(0, 3));
                return slope_value;
            end
        endcase
    endfunction

    task automatic test_directed_cases();
        // empty stack: pop, query and the spare code
        send_item(mts_pkg::OP_POP, 32'sd0);
        send_item(mts_pkg::OP_QUERY, 32'sd0);
        send_item(OP_SPARE, 32'sd0);
        // extremes: INT_MIN below INT_MAX needs the widest encoded word
        send_item(mts_pkg::OP_PUSH, mts_pkg::INT_MAX);
        send_item(mts_pkg::OP_PUSH, INT_MIN_VALUE);
        send_item(mts_pkg::OP_PUSH, mts_pkg::INT_MAX);
        send_item(mts_pkg::OP_QUERY, -32'sd1);
        send_item(OP_SPARE, 32'sh5A5A_A5A5);
        send_item(mts_pkg::OP_POP, 32'sd0);
        send_item(mts_pkg::OP_POP, 32'sd0);
        send_item(mts_pkg::OP_POP, 32'sd0);
        send_item(mts_pkg::OP_POP, 32'sd0);
        // push onto empty after the old minimum; equal values stay plain
        send_item(mts_pkg::OP_PUSH, -32'sd1);
        send_item(mts_pkg::OP_PUSH, -32'sd1);
        send_item(mts_pkg::OP_PUSH, -32'sd5);
        send_item(mts_pkg::OP_PUSH, 32'sd0);
        send_item(mts_pkg::OP_PUSH, -32'sd5);
        send_item(mts_pkg::OP_PUSH, -32'sd6);
        repeat (6) send_item(mts_pkg::OP_POP, $urandom);
        send_item(mts_pkg::OP_POP, $urandom);
    endtask

    task automatic test_fill_and_refuse();
        wait_for_results();
        // start the fill from an empty stack
        repeat (held_count) send_item(mts_pkg::OP_POP, $urandom);
        repeat (DEPTH) send_item(mts_pkg::OP_PUSH, pick_value());
        // full: pushes are refused, query still reports
        repeat (3) send_item(mts_pkg::OP_PUSH, pick_value());
        send_item(mts_pkg::OP_QUERY, $urandom);
        send_item(mts_pkg::OP_POP, $urandom);
        send_item(mts_pkg::OP_PUSH, INT_MIN_VALUE);
        send_item(mts_pkg::OP_PUSH, INT_MIN_VALUE);
    endtask

    task automatic test_backpressure();
        // hold the result side while the sender keeps offering, so the input stalls
        out_hold_cycles = LONG_HOLD_CYCLES;
        in_steady = 1'b1;
        repeat (PRESSURE_ITEMS) begin
            if ($urandom_range(0, 2) != 0)
                send_item(mts_pkg::OP_PUSH, pick_value());
            else
                send_item(mts_pkg::OP_POP, $urandom);
        end
        in_steady = 1'b0;
        // pause the sender until everything has drained
        wait_for_results();
    endtask

    task automatic test_random_mix();
        int         push_pct;
        int         pop_pct;
        int         roll;
        logic [1:0] op;
        push_pct = 45;
        pop_pct = 45;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // pick a new op mix and pacing for each segment
            if (n % SEGMENT_ITEMS == 0) begin
                case ($urandom_range(0, 3))
                    0: begin push_pct = 65; pop_pct = 25; end
                    1: begin push_pct = 25; pop_pct = 65; end
                    2: begin push_pct = 45; pop_pct = 45; end
                    default: begin push_pct = 10; pop_pct = 80; end
                endcase
                in_steady = ($urandom_range(0, 3) == 0);
                out_steady = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                op = mts_pkg::OP_PUSH;
            else if (roll < push_pct + pop_pct)
                op = mts_pkg::OP_POP;
            else
                op = ($urandom_range(0, 1) != 0) ? mts_pkg::OP_QUERY : OP_SPARE;
            send_item(op, (op == mts_pkg::OP_PUSH) ? pick_value() : $signed($urandom));
        end
        in_steady = 1'b0;
        out_steady = 1'b0;
    endtask

    initial begin : run_tests
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_fill_and_refuse();
        test_backpressure();
        test_random_mix();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items and %0d checked results, deepest stack %0d.",
                 items_sent, reports_checked, deepest);
        $display("Encoded pushes %0d, refused pushes %0d, pops on empty %0d.",
                 encoded_pushes, refused_pushes, empty_pops);
        if (fail_count == 0) begin
            $display("tb_min_tracking_stack: PASS");
        end else begin
            $display("tb_min_tracking_stack: FAIL");
        end
        $finish;
    end

    // End a hung run
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("%0t: timeout with %0d results still due", $time, due_reports.size());
        $display("tb_min_tracking_stack: FAIL");
        $finish;
    end

endmodule
